/* rtl/rrrs_pkg.sv */
`timescale 1ns / 1ps
package rrrs_pkg;
    localparam logic [2:0] ST_CLOSED  = 3'd0;
    localparam logic [2:0] ST_SYNRCVD = 3'd1;
    localparam logic [2:0] ST_EST     = 3'd2;
    localparam logic [2:0] ST_FINWAIT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [2:0] K_DELIVER = 3'd0;
    localparam logic [2:0] K_CHAIN   = 3'd1;
    localparam logic [2:0] K_STORE   = 3'd2;
    localparam logic [2:0] K_PKT     = 3'd3;
    localparam logic [2:0] K_CLOSED  = 3'd4;

    localparam logic [2:0] FL_ACK    = 3'd2;
    localparam logic [2:0] FL_SYNACK = 3'd3;
    localparam logic [2:0] FL_FINACK = 3'd6;

    localparam logic CFG_ISN = 1'b0;
    localparam logic CFG_WIN = 1'b1;

    typedef struct packed {
        logic        frame_ok;
        logic [47:0] source_id;
        logic        is_syn;
        logic        is_ack;
        logic        is_fin;
        logic        is_data;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] seg_len;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [4:0]  slot;
        logic [15:0] length;
        logic [31:0] pkt_seq;
        logic [31:0] pkt_ack;
        logic [2:0]  pkt_flags;
        logic [15:0] pkt_window;
        logic [63:0] sack_bits;
        logic        last;
    } t_out;
endpackage

/* rtl/rrrs_if.sv */
`timescale 1ns / 1ps
interface rrrs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/rrrs_slot_search.sv */
`timescale 1ns / 1ps
// one slot compared per cycle; reports first match and first free slot
module rrrs_slot_search #(
    parameter int SLOTS = 32,
    parameter int SW    = 5
) (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic [31:0]      i_key,
    input  logic [SLOTS-1:0] i_valid,
    input  logic [31:0]      i_slot_seq,
    output logic [SW-1:0]    o_idx,
    output logic             o_done,
    output logic             o_hit,
    output logic [SW-1:0]    o_hit_idx,
    output logic             o_free,
    output logic [SW-1:0]    o_free_idx
);
    logic [SW:0]   r_cnt;
    logic          r_busy;
    logic          r_hit;
    logic [SW-1:0] r_hit_idx;
    logic          r_free;
    logic [SW-1:0] r_free_idx;
    logic [SW-1:0] w_cur;
    logic          w_match;

    assign w_cur   = r_cnt[SW-1:0];
    assign o_idx   = w_cur;
    assign w_match = r_busy && i_valid[w_cur] && (i_slot_seq == i_key);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_busy) begin
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= w_cur;
            end
            if (!i_valid[w_cur] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= w_cur;
            end
            r_cnt <= r_cnt + (SW+1)'(1);
            if (r_cnt == (SW+1)'(SLOTS - 1)) r_busy <= 1'b0;
        end
    end

    assign o_done     = !r_busy;
    assign o_hit      = r_hit;
    assign o_hit_idx  = r_hit_idx;
    assign o_free     = r_free;
    assign o_free_idx = r_free_idx;
endmodule

/* rtl/reliable_receiver_reassembly_sack.sv */
`timescale 1ns / 1ps
// slot-table lookups share the single compare unit, one walk at a time
//   lookups per data word = min(SACK_WIDTH, window) + chained slots
//   (+1 for in-order or ahead data)
//   control-only words need no slot-table lookup
// throughput: one input word at a time, next accepted after the last result
// reset: synchronous active low; state closed, slots empty, isn 1000, window 32
module reliable_receiver_reassembly_sack
    import rrrs_pkg::*;
#(
    parameter int SEGMENT_SIZE = 1024,
    parameter int SACK_WIDTH   = 64,
    parameter int BUFFER_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    rrrs_if.sink         in_ch,
    rrrs_if.source       out_ch
);
    localparam int SW = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int CW = $clog2(SACK_WIDTH + 1);

    // sequencer steps
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_CHAIN = 4'd2;
    localparam logic [3:0] S_CWAIT = 4'd3;
    localparam logic [3:0] S_STORE = 4'd4;
    localparam logic [3:0] S_SWAIT = 4'd5;
    localparam logic [3:0] S_SACK  = 4'd6;
    localparam logic [3:0] S_KWAIT = 4'd7;
    localparam logic [3:0] S_ACK   = 4'd8;
    localparam logic [3:0] S_FIN2  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]  r_st, r_ret;
    logic [2:0]  r_conn;
    logic [47:0] r_peer;
    logic [31:0] r_next;
    logic [31:0] r_isn;
    logic [15:0] r_win;
    t_in         r_in;
    t_out        r_out;
    logic        r_ov;
    logic [BUFFER_SLOTS-1:0] r_valid;
    logic [31:0] r_sseq [BUFFER_SLOTS];
    logic [15:0] r_slen [BUFFER_SLOTS];
    logic [63:0] r_mask;
    logic [CW-1:0] r_bit;
    logic [CW-1:0] w_nbits;
    logic [31:0] r_key;
    logic        r_start;
    logic        w_ooo;

    logic [SW-1:0] w_idx, w_hidx, w_fidx;
    logic          w_done, w_hit, w_free;
    logic [31:0]   w_sseq;

    assign w_sseq = r_sseq[w_idx];

    rrrs_slot_search #(.SLOTS(BUFFER_SLOTS), .SW(SW)) u_search (
        .i_clk      (i_clk),
        .i_start    (r_start),
        .i_key      (r_key),
        .i_valid    (r_valid),
        .i_slot_seq (w_sseq),
        .o_idx      (w_idx),
        .o_done     (w_done),
        .o_hit      (w_hit),
        .o_hit_idx  (w_hidx),
        .o_free     (w_free),
        .o_free_idx (w_fidx)
    );

    assign w_nbits = (r_win < 16'(SACK_WIDTH)) ? CW'(r_win) : CW'(SACK_WIDTH);

    // window limit computed without wrap
    logic [47:0] w_lim, w_off;
    assign w_lim = 48'(r_win) * 48'(SEGMENT_SIZE);
    assign w_off = 48'(r_in.seq_num - r_next);

    // data from the peer that lands ahead of the expected sequence number
    assign w_ooo = r_in.frame_ok && (r_conn == ST_EST) && (r_in.source_id == r_peer) &&
                   !r_in.is_fin && r_in.is_data && (r_in.seq_num > r_next);

    assign in_ch.ready  = (r_st == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    function automatic t_out pkt(input logic [31:0] s, input logic [31:0] a,
                                 input logic [2:0] f, input logic [15:0] w,
                                 input logic [63:0] m, input logic l);
        t_out o;
        o = '0;
        o.out_kind = K_PKT; o.pkt_seq = s; o.pkt_ack = a;
        o.pkt_flags = f; o.pkt_window = w; o.sack_bits = m; o.last = l;
        return o;
    endfunction

    // delivery, store and close words carry only kind, slot, length and last flag
    function automatic t_out item_word(input logic [2:0] k, input logic [4:0] s,
                                       input logic [15:0] n, input logic l);
        t_out o;
        o = '0;
        o.out_kind = k; o.slot = s; o.length = n; o.last = l;
        return o;
    endfunction

    // one-cycle pulse that launches a slot-table walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= ((r_st == S_DEC) && w_ooo) || (r_st == S_CHAIN) ||
                       ((r_st == S_STORE) && (r_bit != w_nbits));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_conn  <= ST_CLOSED;
            r_peer  <= '0;
            r_next  <= '0;
            r_isn   <= 32'd1000;
            r_win   <= 16'd32;
            r_ov    <= 1'b0;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ISN: r_isn <= i_cfg_wdata;
                    CFG_WIN: r_win <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (r_ov && out_ch.ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_in <= in_ch.data;
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    if (!r_in.frame_ok || r_conn == ST_DONE) begin
                        r_st <= S_IDLE;
                    end else if (r_conn == ST_CLOSED) begin
                        if (r_in.is_syn) begin
                            r_peer <= r_in.source_id;
                            r_next <= r_in.seq_num + 32'd1;
                            r_conn <= ST_SYNRCVD;
                            r_out  <= pkt(r_isn, r_in.seq_num + 32'd1, FL_SYNACK,
                                          r_win, '0, 1'b1);
                            r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_IDLE;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end else if (r_in.source_id != r_peer) begin
                        r_st <= S_IDLE;
                    end else if (r_conn == ST_SYNRCVD) begin
                        if (r_in.is_ack && r_in.ack_num == r_isn + 32'd1)
                            r_conn <= ST_EST;
                        r_st <= S_IDLE;
                    end else if (r_conn == ST_EST) begin
                        if (r_in.is_fin) begin
                            r_out <= pkt(r_isn + 32'd1, r_in.seq_num + 32'd1, FL_ACK,
                                         r_win, '0, 1'b0);
                            r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_FIN2;
                        end else if (r_in.is_data) begin
                            if (r_in.seq_num == r_next) begin
                                r_out  <= item_word(K_DELIVER, 5'd0, r_in.seg_len, 1'b0);
                                r_next <= r_next + 32'(r_in.seg_len);
                                r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_CHAIN;
                            end else if (r_in.seq_num > r_next) begin
                                r_key <= r_in.seq_num;
                                r_st <= S_SWAIT;
                            end else begin
                                r_st <= S_SACK;
                            end
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end else if (r_conn == ST_FINWAIT && r_in.is_ack) begin
                        r_out  <= item_word(K_CLOSED, 5'd0, 16'd0, 1'b1);
                        r_conn <= ST_DONE;
                        r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_IDLE;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_OUT: if (!r_ov || out_ch.ready) r_st <= r_ret;
                S_FIN2: begin
                    r_out <= pkt(r_isn + 32'd2, r_next, FL_FINACK, r_win, '0, 1'b1);
                    r_conn <= ST_FINWAIT;
                    r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_IDLE;
                end
                S_CHAIN: begin
                    r_key <= r_next; r_st <= S_CWAIT;
                end
                S_CWAIT: if (!r_start && w_done) begin
                    if (w_hit) begin
                        r_out  <= item_word(K_CHAIN, 5'(w_hidx), r_slen[w_hidx], 1'b0);
                        r_next <= r_next + 32'(r_slen[w_hidx]);
                        r_valid[w_hidx] <= 1'b0;
                        r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_CHAIN;
                    end else begin
                        r_st <= S_SACK;
                    end
                end
                S_SWAIT: if (!r_start && w_done) begin
                    if (w_off < w_lim && w_free && !w_hit) begin
                        r_valid[w_fidx] <= 1'b1;
                        r_sseq[w_fidx]  <= r_in.seq_num;
                        r_slen[w_fidx]  <= r_in.seg_len;
                        r_out <= item_word(K_STORE, 5'(w_fidx), r_in.seg_len, 1'b0);
                        r_ov <= 1'b1; r_st <= S_OUT; r_ret <= S_SACK;
                    end else begin
                        r_st <= S_SACK;
                    end
                end
                S_SACK: begin
                    r_mask <= '0; r_bit <= '0;
                    r_st <= S_STORE;
                end
                S_STORE: begin
                    // launch lookup of next sack bit, or go on to the ack once all bits are done
                    if (r_bit == w_nbits) begin
                        r_st <= S_ACK;
                    end else begin
                        r_key <= r_next + (32'(r_bit) + 32'd1) * 32'(SEGMENT_SIZE);
                        r_st <= S_KWAIT;
                    end
                end
                S_KWAIT: if (!r_start && w_done) begin
                    if (w_hit) r_mask[6'(r_bit)] <= 1'b1;
                    r_bit <= r_bit + CW'(1);
                    r_st <= S_STORE;
                end
                S_ACK: if (!r_ov) begin
                    r_out <= pkt(r_isn + 32'd1, r_next, FL_ACK, r_win, r_mask, 1'b1);
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // no new word while a sequence is running
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    // done state never leaves
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_conn == ST_DONE) |=> (r_conn == ST_DONE)) else $error("left done");
`endif
endmodule
